// ===== rtl/tmma_pkg.sv =====
// Shared constants, types and helpers of the tile multiply-accumulate unit.
package tmma_pkg;

   localparam int TILE_MAX = 8;
   localparam int IDX_W    = $clog2(TILE_MAX);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DEPTH    = TILE_MAX * TILE_MAX;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int SIZE_W   = 4;

   localparam logic [SIZE_W-1:0] TILE_SIZE_RESET = SIZE_W'(TILE_MAX);

   // Command codes
   localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 3'd1;
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_ACC   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ACC  = 3'd4;

   // Control that travels with one multiply-add step down the pipeline
   typedef struct packed {
      logic              valid;
      logic              first;     // first k of an accumulator entry
      logic              last;      // last k of an accumulator entry
      logic              tail;      // last step of the whole accumulate
      logic [ADDR_W-1:0] acc_addr;
   } beat_type;

   // Limit the programmed tile size to the storage
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] res;
      res = size;
      if (size > SIZE_W'(TILE_MAX)) begin
         res = SIZE_W'(TILE_MAX);
      end
      return res;
   endfunction

endpackage

// ===== rtl/tmma_ram.sv =====
// Single-port-write, single-port-read tile memory with registered read data.
module tmma_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [tmma_pkg::ADDR_W-1:0] wr_addr,
   input  logic [tmma_pkg::DATA_W-1:0] wr_data,
   input  logic [tmma_pkg::ADDR_W-1:0] rd_addr,
   output logic [tmma_pkg::DATA_W-1:0] rd_data
);

   logic [tmma_pkg::DATA_W-1:0] mem [tmma_pkg::DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/tmma_seq.sv =====
// Step sequencer: walks row, column and k over the active tile size.
module tmma_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tmma_pkg::SIZE_W-1:0] tile_n,
   output tmma_pkg::beat_type          beat,
   output logic [tmma_pkg::ADDR_W-1:0] left_raddr,
   output logic [tmma_pkg::ADDR_W-1:0] right_raddr,
   output logic [tmma_pkg::ADDR_W-1:0] acc_raddr
);

   logic                        active_ff, active_in;
   logic [tmma_pkg::SIZE_W-1:0] n_ff, n_in;
   logic [tmma_pkg::IDX_W-1:0]  r_ff, r_in;
   logic [tmma_pkg::IDX_W-1:0]  c_ff, c_in;
   logic [tmma_pkg::IDX_W-1:0]  k_ff, k_in;
   logic [tmma_pkg::SIZE_W-1:0] n_top;
   logic                        last_r;
   logic                        last_c;
   logic                        last_k;

   // Compare each counter with the last index in use
   assign n_top  = n_ff - tmma_pkg::SIZE_W'(1);
   assign last_r = (tmma_pkg::SIZE_W'(r_ff) == n_top);
   assign last_c = (tmma_pkg::SIZE_W'(c_ff) == n_top);
   assign last_k = (tmma_pkg::SIZE_W'(k_ff) == n_top);

   // Issue memory addresses for the current step
   assign left_raddr  = {r_ff, k_ff};
   assign right_raddr = {k_ff, c_ff};
   assign acc_raddr   = {r_ff, c_ff};

   always_comb begin
      beat.valid    = active_ff;
      beat.first    = (k_ff == '0);
      beat.last     = last_k;
      beat.tail     = last_k && last_c && last_r;
      beat.acc_addr = {r_ff, c_ff};
   end

   // Advance k innermost, then column, then row
   always_comb begin
      active_in = active_ff;
      n_in      = n_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      if (start) begin
         active_in = 1'b1;
         n_in      = tile_n;
         r_in      = '0;
         c_in      = '0;
         k_in      = '0;
      end else if (active_ff) begin
         if (last_k) begin
            k_in = '0;
            if (last_c) begin
               c_in = '0;
               if (last_r) begin
                  active_in = 1'b0;
               end else begin
                  r_in = r_ff + tmma_pkg::IDX_W'(1);
               end
            end else begin
               c_in = c_ff + tmma_pkg::IDX_W'(1);
            end
         end else begin
            k_in = k_ff + tmma_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
   end

endmodule

// ===== rtl/tmma_mac.sv =====
// Multiply-accumulate pipeline: multiply stage, then add into running sum.
module tmma_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  tmma_pkg::beat_type          beat,
   input  logic [tmma_pkg::DATA_W-1:0] left_data,
   input  logic [tmma_pkg::DATA_W-1:0] right_data,
   input  logic [tmma_pkg::DATA_W-1:0] acc_base,
   output logic                        acc_we,
   output logic [tmma_pkg::ADDR_W-1:0] acc_waddr,
   output logic [tmma_pkg::DATA_W-1:0] acc_wdata,
   output logic                        done
);

   tmma_pkg::beat_type          beat1_ff;
   tmma_pkg::beat_type          beat2_ff;
   logic [tmma_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [tmma_pkg::DATA_W-1:0] base_ff;
   logic [tmma_pkg::DATA_W-1:0] sum_ff, sum_in;

   // Align control with the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         beat1_ff.valid <= 1'b0;
         beat2_ff.valid <= 1'b0;
      end else begin
         beat1_ff.valid <= beat.valid;
         beat2_ff.valid <= beat1_ff.valid;
      end
      beat1_ff.first    <= beat.first;
      beat1_ff.last     <= beat.last;
      beat1_ff.tail     <= beat.tail;
      beat1_ff.acc_addr <= beat.acc_addr;
      beat2_ff.first    <= beat1_ff.first;
      beat2_ff.last     <= beat1_ff.last;
      beat2_ff.tail     <= beat1_ff.tail;
      beat2_ff.acc_addr <= beat1_ff.acc_addr;
   end

   // Multiply, keeping the low word
   assign prod_in = tmma_pkg::DATA_W'(left_data * right_data);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= acc_base;
   end

   // Add: start from the stored entry on the first k, else the running sum
   assign sum_in = (beat2_ff.first ? base_ff : sum_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (beat2_ff.valid) begin
         sum_ff <= sum_in;
      end
   end

   // Write back the finished entry
   assign acc_we    = beat2_ff.valid && beat2_ff.last;
   assign acc_waddr = beat2_ff.acc_addr;
   assign acc_wdata = sum_in;
   assign done      = beat2_ff.valid && beat2_ff.tail;

endmodule

// ===== rtl/tile_matrix_multiply_accumulate_unit.sv =====
// Top level of the tile multiply-accumulate unit: command decode and responses.
//
// Usage: commands arrive as beats on the req_ channel (valid/ready) and each
// gives exactly one beat on the rsp_ channel: rsp_done_op echoes the command,
// rsp_read_value carries the accumulator entry for a read and zero otherwise.
// csr_write_enable/csr_write_data set the tile size n; write it only while idle.
// Response timing and throughput:
//   load left, load right, clear, unknown op: response registered in the cycle
//     after accept, one command per cycle sustained while rsp_ready is high.
//   read accumulator: response via the read state, which waits for the memory
//     read data, and then the response register.
//   accumulate: n*n*n multiply-add steps, one per cycle through a single
//     multiplier fed by the left and right tile memories, then the memory read,
//     the product register and the response register. With n zero it runs no steps.
// A new command is taken only when the unit is idle and the response register
// is empty or being drained in the same cycle; a stalled receiver therefore
// holds the finished response and blocks the next command after one beat.
// Reset (synchronous, active high): tile size returns to 8, the accumulator
// reads as all zero through per-entry valid bits (no clearing pass), and the
// left and right tiles are undefined until loaded.
module tile_matrix_multiply_accumulate_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic        [tmma_pkg::OP_W-1:0]   req_op,
   input  logic        [tmma_pkg::IDX_W-1:0]  req_row_index,
   input  logic        [tmma_pkg::IDX_W-1:0]  req_col_index,
   input  logic signed [tmma_pkg::DATA_W-1:0] req_element_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tmma_pkg::DATA_W-1:0] rsp_read_value,
   output logic        [tmma_pkg::OP_W-1:0]   rsp_done_op,
   input  logic                               csr_write_enable,
   input  logic        [tmma_pkg::SIZE_W-1:0] csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_ACC  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [tmma_pkg::OP_W-1:0]     op_ff, op_in;
   logic [tmma_pkg::SIZE_W-1:0]   tile_size_ff, tile_size_in;
   logic [tmma_pkg::DEPTH-1:0]    acc_valid_ff, acc_valid_in;
   logic [tmma_pkg::ADDR_W-1:0]   acc_raddr_q_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tmma_pkg::DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [tmma_pkg::OP_W-1:0]     rsp_op_ff, rsp_op_in;

   logic                          req_fire;
   logic                          rsp_fire;
   logic [tmma_pkg::ADDR_W-1:0]   req_addr;
   logic [tmma_pkg::SIZE_W-1:0]   tile_n;
   logic                          acc_start;
   logic                          is_load_left;
   logic                          is_load_right;

   tmma_pkg::beat_type            beat_s0;
   logic [tmma_pkg::ADDR_W-1:0]   left_raddr;
   logic [tmma_pkg::ADDR_W-1:0]   right_raddr;
   logic [tmma_pkg::ADDR_W-1:0]   seq_acc_raddr;
   logic [tmma_pkg::ADDR_W-1:0]   acc_raddr;
   logic [tmma_pkg::DATA_W-1:0]   left_rdata;
   logic [tmma_pkg::DATA_W-1:0]   right_rdata;
   logic [tmma_pkg::DATA_W-1:0]   acc_rdata;
   logic [tmma_pkg::DATA_W-1:0]   acc_rd_gated;
   logic                          acc_we;
   logic [tmma_pkg::ADDR_W-1:0]   acc_waddr;
   logic [tmma_pkg::DATA_W-1:0]   acc_wdata;
   logic                          mac_done;

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_addr  = {req_row_index, req_col_index};
   assign tile_n    = tmma_pkg::clamp_size(tile_size_ff);
   assign acc_start = req_fire && (req_op == tmma_pkg::OP_ACCUMULATE) && (tile_n != '0);

   assign is_load_left  = req_fire && (req_op == tmma_pkg::OP_LOAD_LEFT);
   assign is_load_right = req_fire && (req_op == tmma_pkg::OP_LOAD_RIGHT);

   // Tile memories
   tmma_ram u_left_ram (
      .clock   (clock),
      .wr_en   (is_load_left),
      .wr_addr (req_addr),
      .wr_data (tmma_pkg::DATA_W'(req_element_value)),
      .rd_addr (left_raddr),
      .rd_data (left_rdata)
   );

   tmma_ram u_right_ram (
      .clock   (clock),
      .wr_en   (is_load_right),
      .wr_addr (req_addr),
      .wr_data (tmma_pkg::DATA_W'(req_element_value)),
      .rd_addr (right_raddr),
      .rd_data (right_rdata)
   );

   // The accumulator is read by the sequencer while accumulating, else by reads
   assign acc_raddr = (state_ff == ST_ACC) ? seq_acc_raddr : req_addr;

   tmma_ram u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   // An entry not written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      acc_raddr_q_ff <= acc_raddr;
   end

   assign acc_rd_gated = acc_valid_ff[acc_raddr_q_ff] ? acc_rdata : '0;

   tmma_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (acc_start),
      .tile_n      (tile_n),
      .beat        (beat_s0),
      .left_raddr  (left_raddr),
      .right_raddr (right_raddr),
      .acc_raddr   (seq_acc_raddr)
   );

   tmma_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat_s0),
      .left_data  (left_rdata),
      .right_data (right_rdata),
      .acc_base   (acc_rd_gated),
      .acc_we     (acc_we),
      .acc_waddr  (acc_waddr),
      .acc_wdata  (acc_wdata),
      .done       (mac_done)
   );

   // Accumulator entry valid bits: drop all on clear, set on write-back
   always_comb begin
      acc_valid_in = acc_valid_ff;
      if (req_fire && (req_op == tmma_pkg::OP_CLEAR_ACC)) begin
         acc_valid_in = '0;
      end else if (acc_we) begin
         acc_valid_in[acc_waddr] = 1'b1;
      end
   end

   // Tile size register
   assign tile_size_in = csr_write_enable ? csr_write_data : tile_size_ff;

   // Command sequencing and the response register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_op_in    = rsp_op_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in = req_op;
               if (req_op == tmma_pkg::OP_READ_ACC) begin
                  state_in = ST_READ;
               end else if (acc_start) begin
                  state_in = ST_ACC;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_op_in    = req_op;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = acc_rd_gated;
            rsp_op_in    = op_ff;
            state_in     = ST_IDLE;
         end
         ST_ACC: begin
            if (mac_done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_op_in    = op_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tile_size_ff <= tmma_pkg::TILE_SIZE_RESET;
         acc_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tile_size_ff <= tile_size_in;
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rsp_value_ff <= rsp_value_in;
      rsp_op_ff    <= rsp_op_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = signed'(rsp_value_ff);
   assign rsp_done_op    = rsp_op_ff;

   // Checks
   a_step_only_accumulating: assert property (@(posedge clock) disable iff (reset)
      beat_s0.valid |-> (state_ff == ST_ACC))
      else $error("multiply-add step issued outside an accumulate");

   a_writeback_only_accumulating: assert property (@(posedge clock) disable iff (reset)
      acc_we |-> (state_ff == ST_ACC))
      else $error("accumulator written outside an accumulate");

   a_read_takes_one_wait: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == tmma_pkg::OP_READ_ACC)) |=> (state_ff == ST_READ))
      else $error("read command did not wait for memory data");

   a_response_slot_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || mac_done) |-> !rsp_valid_ff)
      else $error("response register occupied when a result completes");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tile multiply-accumulate unit.
module tb;

   // Op codes the unit does not decode
   localparam logic [tmma_pkg::OP_W-1:0] OP_RESERVED_A = 3'd5;
   localparam logic [tmma_pkg::OP_W-1:0] OP_RESERVED_B = 3'd6;
   localparam logic [tmma_pkg::OP_W-1:0] OP_RESERVED_C = 3'd7;

   localparam int WORK_ITEMS      = 850;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_AT     = 200;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef struct packed {
      logic [tmma_pkg::DATA_W-1:0] read_value;
      logic [tmma_pkg::OP_W-1:0]   done_op;
   } tile_rsp_type;

   typedef struct {
      bit                          is_cfg;
      logic [tmma_pkg::SIZE_W-1:0] size;
      logic [tmma_pkg::OP_W-1:0]   op;
      logic [tmma_pkg::IDX_W-1:0]  row;
      logic [tmma_pkg::IDX_W-1:0]  col;
      logic [tmma_pkg::DATA_W-1:0] value;
      bit                          typed;
      logic [tmma_pkg::DATA_W-1:0] want;
   } stim_row_type;

   logic                               clock;
   logic                               reset             = 1'b1;
   logic                               req_valid         = 1'b0;
   logic                               req_ready;
   logic        [tmma_pkg::OP_W-1:0]   req_op            = '0;
   logic        [tmma_pkg::IDX_W-1:0]  req_row_index     = '0;
   logic        [tmma_pkg::IDX_W-1:0]  req_col_index     = '0;
   logic signed [tmma_pkg::DATA_W-1:0] req_element_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready         = 1'b0;
   logic signed [tmma_pkg::DATA_W-1:0] rsp_read_value;
   logic        [tmma_pkg::OP_W-1:0]   rsp_done_op;
   logic                               csr_write_enable  = 1'b0;
   logic        [tmma_pkg::SIZE_W-1:0] csr_write_data    = '0;

   // Tile contents and tile size as the unit should hold them
   logic [tmma_pkg::DATA_W-1:0] left_tile_img  [tmma_pkg::DEPTH];
   logic [tmma_pkg::DATA_W-1:0] right_tile_img [tmma_pkg::DEPTH];
   logic [tmma_pkg::DATA_W-1:0] acc_tile_img   [tmma_pkg::DEPTH];
   logic [tmma_pkg::SIZE_W-1:0] tile_size_img = tmma_pkg::TILE_SIZE_RESET;
   tile_rsp_type                owed_responses[$];

   // Typed-in read value for the beat on the request port, if any
   bit                          cur_typed = 1'b0;
   logic [tmma_pkg::DATA_W-1:0] cur_want  = '0;

   logic req_beat = 1'b0;
   logic rsp_beat = 1'b0;
   bit   send_burst = 1'b0;
   int   fail_count = 0;
   int   responses_checked = 0;
   int   work_items = 0;
   int   accumulates = 0;
   int   reads = 0;
   int   clears = 0;
   int   size_writes = 0;
   int   stall_cycles = 0;

   tile_matrix_multiply_accumulate_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_done_op       (rsp_done_op),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (acc_tile_img[i]) begin
         left_tile_img[i]  = '0;
         right_tile_img[i] = '0;
         acc_tile_img[i]   = '0;
      end
   end

   // Apply one command to the tile images and return the response it owes
   function automatic tile_rsp_type execute_tile_command(
         input logic [tmma_pkg::OP_W-1:0] op,
         input logic [tmma_pkg::IDX_W-1:0] row, input logic [tmma_pkg::IDX_W-1:0] col,
         input logic [tmma_pkg::DATA_W-1:0] value);
      tile_rsp_type                rsp;
      int                          n;
      int                          addr;
      logic [tmma_pkg::DATA_W-1:0] sum;
      rsp.read_value = '0;
      rsp.done_op    = op;
      addr = int'(row) * tmma_pkg::TILE_MAX + int'(col);
      n = (tile_size_img > tmma_pkg::TILE_MAX) ? tmma_pkg::TILE_MAX : int'(tile_size_img);
      case (op)
         tmma_pkg::OP_LOAD_LEFT:  left_tile_img[addr]  = value;
         tmma_pkg::OP_LOAD_RIGHT: right_tile_img[addr] = value;
         tmma_pkg::OP_READ_ACC:   rsp.read_value = acc_tile_img[addr];
         tmma_pkg::OP_CLEAR_ACC: begin
            foreach (acc_tile_img[i]) acc_tile_img[i] = '0;
         end
         tmma_pkg::OP_ACCUMULATE: begin
            for (int r = 0; r < n; r++) begin
               for (int c = 0; c < n; c++) begin
                  sum = acc_tile_img[r * tmma_pkg::TILE_MAX + c];
                  for (int k = 0; k < n; k++) begin
                     sum = sum + left_tile_img[r * tmma_pkg::TILE_MAX + k] *
                                 right_tile_img[k * tmma_pkg::TILE_MAX + c];
                  end
                  acc_tile_img[r * tmma_pkg::TILE_MAX + c] = sum;
               end
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic report_mismatch(input string what,
         input logic [tmma_pkg::DATA_W-1:0] got, input logic [tmma_pkg::DATA_W-1:0] want);
      $display("MISMATCH %s: got %h, wanted %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Score response beats, predict request beats, track tile size writes
   always @(posedge clock) begin
      tile_rsp_type got;
      tile_rsp_type want;
      req_beat <= req_valid && req_ready;
      rsp_beat <= rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_read_value, rsp_done_op};
            if (owed_responses.size() == 0) begin
               report_mismatch("response with nothing owed", got.read_value, '0);
            end else begin
               want = owed_responses.pop_front();
               if (got.done_op != want.done_op) begin
                  report_mismatch("done_op", tmma_pkg::DATA_W'(got.done_op),
                                  tmma_pkg::DATA_W'(want.done_op));
               end
               if (got.read_value != want.read_value) begin
                  report_mismatch("read_value", got.read_value, want.read_value);
               end
            end
            responses_checked++;
         end
         if (req_valid && req_ready) begin
            want = execute_tile_command(req_op, req_row_index, req_col_index,
                                        req_element_value);
            if (cur_typed) begin
               want.read_value = cur_want;
            end
            owed_responses.push_back(want);
         end
         if (csr_write_enable) begin
            tile_size_img = csr_write_data;
         end
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d responses owed",
                     STALL_LIMIT, owed_responses.size());
            $display("FAIL tile_matrix_multiply_accumulate_unit");
            $finish;
         end
      end
   end

   // Draw a random wait per item, with occasional stretches of back-to-back beats
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 15) == 0) begin
         burst = !burst;
      end
      return burst ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic logic [tmma_pkg::DATA_W-1:0] draw_value();
      case ($urandom_range(0, 15))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         4:       return 32'h0000_0001;
         5, 6:    return tmma_pkg::DATA_W'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type cmd_row(input logic [tmma_pkg::OP_W-1:0] op,
         input int row, input int col, input logic [tmma_pkg::DATA_W-1:0] value,
         input bit typed, input logic [tmma_pkg::DATA_W-1:0] want);
      stim_row_type s;
      s.is_cfg = 1'b0;
      s.size   = '0;
      s.op     = op;
      s.row    = tmma_pkg::IDX_W'(row);
      s.col    = tmma_pkg::IDX_W'(col);
      s.value  = value;
      s.typed  = typed;
      s.want   = want;
      return s;
   endfunction

   function automatic stim_row_type cfg_row(input logic [tmma_pkg::SIZE_W-1:0] size);
      stim_row_type s;
      s = cmd_row(tmma_pkg::OP_LOAD_LEFT, 0, 0, '0, 1'b0, '0);
      s.is_cfg = 1'b1;
      s.size   = size;
      return s;
   endfunction

   // Offer one command beat and hold it until accepted
   task automatic send_command(input logic [tmma_pkg::OP_W-1:0] op,
         input logic [tmma_pkg::IDX_W-1:0] row, input logic [tmma_pkg::IDX_W-1:0] col,
         input logic [tmma_pkg::DATA_W-1:0] value,
         input bit typed, input logic [tmma_pkg::DATA_W-1:0] want);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_row_index     <= row;
      req_col_index     <= col;
      req_element_value <= value;
      cur_typed = typed;
      cur_want  = want;
      do @(negedge clock); while (!req_beat);
      if (op <= tmma_pkg::OP_CLEAR_ACC) work_items++;
      if (op == tmma_pkg::OP_ACCUMULATE) accumulates++;
      if (op == tmma_pkg::OP_READ_ACC) reads++;
      if (op == tmma_pkg::OP_CLEAR_ACC) clears++;
   endtask

   // Drain the unit, then write the tile size
   task automatic write_tile_size(input logic [tmma_pkg::SIZE_W-1:0] size);
      req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      size_writes++;
   endtask

   // Receiver: random ready stalls, plus one long hold-off to back up the unit
   initial begin
      int wait_cycles;
      bit burst;
      bit held;
      burst = 1'b0;
      held  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && responses_checked >= HOLD_OFF_AT) begin
            held = 1'b1;
            wait_cycles = HOLD_OFF_CYCLES;
         end else begin
            wait_cycles = draw_gap(burst);
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_beat);
      end
   end

   // Stimulus: reset, directed table, then random phases at various tile sizes
   initial begin
      stim_row_type                directed_table[$];
      logic [tmma_pkg::SIZE_W-1:0] size;
      logic [tmma_pkg::IDX_W-1:0]  row;
      logic [tmma_pkg::IDX_W-1:0]  col;
      int                          n;
      int                          pick;
      int                          phase;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Accumulator reads zero after reset; unknown ops and loads answer zero
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 7, 7, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(OP_RESERVED_A, 7, 7, 32'hffff_ffff, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(OP_RESERVED_B, 3, 5, 32'h1234_5678, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(OP_RESERVED_C, 0, 0, 32'h8000_0000, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_LEFT, 0, 0, 32'h7fff_ffff,
                                       1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_RIGHT, 0, 0, 32'h8000_0000,
                                       1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_LEFT, 7, 7, 32'hffff_ffff,
                                       1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_RIGHT, 7, 7, 32'h7fff_ffff,
                                       1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_CLEAR_ACC, 0, 0, 32'h0, 1'b1, 32'h0));
      // One-by-one tile: max times min wraps; entries outside the tile stay put
      directed_table.push_back(cfg_row(4'd1));
      directed_table.push_back(cmd_row(tmma_pkg::OP_ACCUMULATE, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 0, 0, 32'h0, 1'b0, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 7, 7, 32'h0, 1'b0, 32'h0));
      // Zero tile size leaves the accumulator alone
      directed_table.push_back(cfg_row(4'd0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_ACCUMULATE, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 0, 0, 32'h0, 1'b0, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_LEFT, 0, 0, 32'hffff_ffff,
                                       1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_LOAD_RIGHT, 0, 0, 32'hffff_ffff,
                                       1'b1, 32'h0));
      directed_table.push_back(cfg_row(4'd1));
      directed_table.push_back(cmd_row(tmma_pkg::OP_ACCUMULATE, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 0, 0, 32'h0, 1'b0, 32'h0));
      // Clear empties the accumulator, checked at both corner entries
      directed_table.push_back(cmd_row(tmma_pkg::OP_CLEAR_ACC, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 0, 0, 32'h0, 1'b1, 32'h0));
      directed_table.push_back(cmd_row(tmma_pkg::OP_READ_ACC, 7, 7, 32'h0, 1'b1, 32'h0));

      foreach (directed_table[i]) begin
         if (directed_table[i].is_cfg) begin
            write_tile_size(directed_table[i].size);
         end else begin
            send_command(directed_table[i].op, directed_table[i].row,
                         directed_table[i].col, directed_table[i].value,
                         directed_table[i].typed, directed_table[i].want);
         end
      end

      // Each phase: set a size, fill both tiles over it, then mixed traffic
      phase = 0;
      while (work_items < WORK_ITEMS) begin
         case (phase)
            0: size = 4'd1;
            1: size = 4'd8;
            2: size = 4'd0;
            3: size = 4'd15;
            default: begin
               pick = $urandom_range(0, 19);
               if (pick < 12) size = tmma_pkg::SIZE_W'($urandom_range(1, 3));
               else if (pick < 17) size = tmma_pkg::SIZE_W'($urandom_range(4, 6));
               else if (pick < 19) size = tmma_pkg::SIZE_W'($urandom_range(7, 8));
               else if ($urandom_range(0, 1) == 0) size = 4'd0;
               else size = tmma_pkg::SIZE_W'($urandom_range(9, 15));
            end
         endcase
         phase++;
         write_tile_size(size);
         n = (size > tmma_pkg::TILE_MAX) ? tmma_pkg::TILE_MAX : int'(size);

         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               send_command(tmma_pkg::OP_LOAD_LEFT, tmma_pkg::IDX_W'(r),
                            tmma_pkg::IDX_W'(c), draw_value(), 1'b0, '0);
               send_command(tmma_pkg::OP_LOAD_RIGHT, tmma_pkg::IDX_W'(c),
                            tmma_pkg::IDX_W'(r), draw_value(), 1'b0, '0);
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  send_command(tmma_pkg::OP_W'($urandom_range(OP_RESERVED_A, OP_RESERVED_C)),
                               tmma_pkg::IDX_W'($urandom), tmma_pkg::IDX_W'($urandom),
                               $urandom, 1'b0, '0);
               end else if (pick == 1) begin
                  send_command(tmma_pkg::OP_READ_ACC, tmma_pkg::IDX_W'($urandom),
                               tmma_pkg::IDX_W'($urandom), $urandom, 1'b0, '0);
               end
            end
         end

         repeat ($urandom_range(6, 20)) begin
            // Mostly address inside the tile, sometimes anywhere in storage
            if (n > 0 && $urandom_range(0, 3) != 0) begin
               row = tmma_pkg::IDX_W'($urandom_range(0, n - 1));
               col = tmma_pkg::IDX_W'($urandom_range(0, n - 1));
            end else begin
               row = tmma_pkg::IDX_W'($urandom);
               col = tmma_pkg::IDX_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               send_command(tmma_pkg::OP_ACCUMULATE, row, col, $urandom, 1'b0, '0);
            end else if (pick < 55) begin
               send_command(tmma_pkg::OP_READ_ACC, row, col, $urandom, 1'b0, '0);
            end else if (pick < 70) begin
               send_command(tmma_pkg::OP_LOAD_LEFT, row, col, draw_value(), 1'b0, '0);
            end else if (pick < 85) begin
               send_command(tmma_pkg::OP_LOAD_RIGHT, row, col, draw_value(), 1'b0, '0);
            end else if (pick < 92) begin
               send_command(tmma_pkg::OP_CLEAR_ACC, row, col, $urandom, 1'b0, '0);
            end else begin
               send_command(tmma_pkg::OP_W'($urandom_range(OP_RESERVED_A, OP_RESERVED_C)),
                            row, col, $urandom, 1'b0, '0);
            end
         end
      end

      // Let the last responses drain
      req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(negedge clock);
      repeat (4 * DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d commands over %0d tile size settings: %0d accumulates,",
               work_items, size_writes, accumulates);
      $display("  %0d reads, %0d clears; %0d responses checked, one long receiver hold-off",
               reads, clears, responses_checked);
      if (fail_count == 0) begin
         $display("PASS tile_matrix_multiply_accumulate_unit");
      end else begin
         $display("FAIL tile_matrix_multiply_accumulate_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tmma_pkg.sv
rtl/tmma_ram.sv
rtl/tmma_seq.sv
rtl/tmma_mac.sv
rtl/tile_matrix_multiply_accumulate_unit.sv
verif/tb.sv
